// ===== src/upi_pkg.sv =====
// ============================================================================
// upi_pkg: shared types and constants of the unicycle pose integrator.
// It holds the CORDIC angle table, the register indexes, and the sequencer states.
// ============================================================================
`default_nettype none
package upi_pkg;
	localparam int CordicSteps = 16;
	localparam int StepW = $clog2(CordicSteps);
	localparam logic signed [33:0] CordicStart = 34'sd652032874;
	localparam logic [0:0] CfgStepTime = 1'b0;
	localparam logic [0:0] CfgRuleMode = 1'b1;
	localparam logic KindStep = 1'b0;
	localparam logic KindLoad = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CORDIC,
		ST_MUL_X,
		ST_MUL_Y,
		ST_MUL_H,
		ST_UPDATE,
		ST_OUT
	} upi_state_t;

	function automatic logic signed [33:0] atan_entry(input logic [StepW-1:0] i);
		logic signed [33:0] r;
		begin
			case (i)
				4'd0: r = 34'sh020000000;
				4'd1: r = 34'sh012E4051E;
				4'd2: r = 34'sh009FB385B;
				4'd3: r = 34'sh0051111D4;
				4'd4: r = 34'sh0028B0D43;
				4'd5: r = 34'sh00145D7E1;
				4'd6: r = 34'sh000A2F61E;
				4'd7: r = 34'sh000517C55;
				4'd8: r = 34'sh00028BE53;
				4'd9: r = 34'sh000145F2F;
				4'd10: r = 34'sh0000A2F98;
				4'd11: r = 34'sh0000517CC;
				4'd12: r = 34'sh000028BE6;
				4'd13: r = 34'sh0000145F3;
				4'd14: r = 34'sh00000A2FA;
				default: r = 34'sh00000517D;
			endcase
			return r;
		end
	endfunction
endpackage
`default_nettype wire

// ===== src/unicycle_pose_integrator.sv =====
// ============================================================================
// unicycle_pose_integrator: fixed-point unicycle dead reckoning.
// Euler or trapezoid integration of speed and turn rate onto a pose with saturating position and wrapping heading.
// ============================================================================
// Channel   Dir  Transaction payload
// s_axis    in   kind, speed, turn_rate, load_x, load_y, load_heading
// m_axis    out  out_x, out_y, out_heading
// cfg       in   register index and write data
// A step item passes from its input transaction through the CORDIC (start and
// 16 iterations), three bit-serial multiplies by step_time through one shared
// multiplier, and the pose update state to its result.
// A load item's result is offered the cycle after it is taken. One item is in
// work at a time; the result register holds while m_axis_tready is low, and a
// new item is taken the cycle after it has left. Reset clears the pose and the
// previous command.
`default_nettype none
module unicycle_pose_integrator (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	// speed[15:0], turn_rate[39:16], load_x[71:40], load_y[103:72],
	// load_heading[119:104], zeros
	input wire logic [127:0] s_axis_tdata,
	// kind[0]
	input wire logic s_axis_tuser,
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	// out_x[31:0], out_y[63:32], out_heading[79:64]
	output logic [79:0] m_axis_tdata,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [0:0] cfg_index,
	input wire logic [15:0] cfg_data
);
	upi_pkg::upi_state_t state_q, state_n;
	logic [15:0] step_time_q;
	logic rule_mode_q;
	logic signed [31:0] east_q, north_q;
	logic [15:0] head_q;
	logic signed [15:0] prev_spd_q;
	logic signed [23:0] prev_trn_q;
	logic signed [16:0] ssum_q;
	logic signed [24:0] rsum_q;
	logic signed [49:0] px_q, py_q;
	logic cor_start, cor_done, mul_start, mul_done;
	logic signed [17:0] cos_v, sin_v;
	logic signed [33:0] mcand;
	logic signed [49:0] prod;
	logic signed [33:0] sc_x, sc_y;
	logic signed [49:0] dx, dy, dh;
	logic signed [33:0] nx, ny;
	logic accept;

	assign cfg_ready = 1'b1;
	assign s_axis_tready = (state_q == upi_pkg::ST_IDLE);
	assign accept = s_axis_tvalid && s_axis_tready;

	upi_cordic u_cordic (.clk, .arst_n, .start(cor_start), .angle(head_q),
		.done(cor_done), .cos_val(cos_v), .sin_val(sin_v));
	upi_serial_mul u_mul (.clk, .arst_n, .start(mul_start), .mcand(mcand),
		.mplier(step_time_q), .done(mul_done), .product(prod));

	always_comb begin
		state_n = state_q;
		case (state_q)
			upi_pkg::ST_IDLE:
				if (accept) state_n = (s_axis_tuser == upi_pkg::KindLoad) ?
					upi_pkg::ST_OUT : upi_pkg::ST_CORDIC;
			upi_pkg::ST_CORDIC: if (cor_done) state_n = upi_pkg::ST_MUL_X;
			upi_pkg::ST_MUL_X: if (mul_done) state_n = upi_pkg::ST_MUL_Y;
			upi_pkg::ST_MUL_Y: if (mul_done) state_n = upi_pkg::ST_MUL_H;
			upi_pkg::ST_MUL_H: if (mul_done) state_n = upi_pkg::ST_UPDATE;
			upi_pkg::ST_UPDATE: state_n = upi_pkg::ST_OUT;
			upi_pkg::ST_OUT: if (m_axis_tready) state_n = upi_pkg::ST_IDLE;
			default: state_n = upi_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		sc_x = 34'(ssum_q) * 34'(cos_v);
		sc_y = 34'(ssum_q) * 34'(sin_v);
		cor_start = accept && (s_axis_tuser == upi_pkg::KindStep);
		mul_start = 1'b0;
		mcand = sc_x;
		case (state_q)
			upi_pkg::ST_CORDIC: mul_start = cor_done;
			upi_pkg::ST_MUL_X: begin
				mul_start = mul_done;
				mcand = sc_y;
			end
			upi_pkg::ST_MUL_Y: begin
				mul_start = mul_done;
				mcand = 34'(rsum_q);
			end
			default: mul_start = 1'b0;
		endcase
		dx = (px_q + 50'sd4194304) >>> 23;
		dy = (py_q + 50'sd4194304) >>> 23;
		dh = (prod + 50'sd65536) >>> 17;
		nx = 34'(east_q) + 34'(dx);
		ny = 34'(north_q) + 34'(dy);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= upi_pkg::ST_IDLE;
			step_time_q <= 16'd655;
			rule_mode_q <= 1'b0;
			east_q <= '0;
			north_q <= '0;
			head_q <= '0;
			prev_spd_q <= '0;
			prev_trn_q <= '0;
		end else begin
			state_q <= state_n;
			if (cfg_valid) begin
				if (cfg_index == upi_pkg::CfgStepTime) step_time_q <= cfg_data;
				else rule_mode_q <= cfg_data[0];
			end
			if (accept) begin
				prev_spd_q <= s_axis_tdata[15:0];
				prev_trn_q <= s_axis_tdata[39:16];
				if (rule_mode_q) begin
					ssum_q <= 17'(signed'(s_axis_tdata[15:0])) + 17'(prev_spd_q);
					rsum_q <= 25'(signed'(s_axis_tdata[39:16])) + 25'(prev_trn_q);
				end else begin
					ssum_q <= {signed'(s_axis_tdata[15:0]), 1'b0};
					rsum_q <= {signed'(s_axis_tdata[39:16]), 1'b0};
				end
				if (s_axis_tuser == upi_pkg::KindLoad) begin
					east_q <= s_axis_tdata[71:40];
					north_q <= s_axis_tdata[103:72];
					head_q <= s_axis_tdata[119:104];
				end
			end
			if (mul_done && state_q == upi_pkg::ST_MUL_X) px_q <= prod;
			if (mul_done && state_q == upi_pkg::ST_MUL_Y) py_q <= prod;
			if (mul_done && state_q == upi_pkg::ST_MUL_H) head_q <= head_q + dh[15:0];
			if (state_q == upi_pkg::ST_UPDATE) begin
				east_q <= (nx > 34'sd2147483647) ? 32'sh7FFFFFFF :
					(nx < -34'sd2147483648) ? 32'sh80000000 : nx[31:0];
				north_q <= (ny > 34'sd2147483647) ? 32'sh7FFFFFFF :
					(ny < -34'sd2147483648) ? 32'sh80000000 : ny[31:0];
			end
		end
	end

	assign m_axis_tvalid = (state_q == upi_pkg::ST_OUT);
	assign m_axis_tdata = {head_q, north_q, east_q};
endmodule
`default_nettype wire

// ===== src/upi_cordic.sv =====
// ============================================================================
// upi_cordic: iterative rotation CORDIC, one micro-rotation per cycle.
// Produces cosine and sine of a 16-bit binary angle in Q4.14.
// ============================================================================
`default_nettype none
module upi_cordic (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [15:0] angle,
	output logic done,
	output logic signed [17:0] cos_val,
	output logic signed [17:0] sin_val
);
	logic signed [33:0] x_q, y_q, z_q;
	logic [upi_pkg::StepW-1:0] i_q;
	logic busy_q, flip_q;
	logic [31:0] z0;
	logic signed [33:0] xs, ys, xr, yr;

	always_comb begin
		z0 = {angle, 16'h0000};
		if (angle[15] ^ angle[14]) z0 = z0 ^ 32'h8000_0000;
		xs = x_q >>> i_q;
		ys = y_q >>> i_q;
		xr = x_q + 34'sd32768;
		yr = y_q + 34'sd32768;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			i_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q <= '0;
				flip_q <= angle[15] ^ angle[14];
				x_q <= upi_pkg::CordicStart;
				y_q <= '0;
				z_q <= {{2{z0[31]}}, z0};
			end else if (busy_q) begin
				if (!z_q[33]) begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - upi_pkg::atan_entry(i_q);
				end else begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + upi_pkg::atan_entry(i_q);
				end
				i_q <= i_q + 1'b1;
				if (i_q == upi_pkg::StepW'(upi_pkg::CordicSteps - 1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	assign cos_val = flip_q ? -xr[33:16] : xr[33:16];
	assign sin_val = flip_q ? -yr[33:16] : yr[33:16];
endmodule
`default_nettype wire

// ===== src/upi_serial_mul.sv =====
// ============================================================================
// upi_serial_mul: shift-and-add signed multiplier, one multiplier bit a cycle.
// Multiplies a 34-bit signed value by an unsigned 16-bit step time.
// ============================================================================
`default_nettype none
module upi_serial_mul (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic signed [33:0] mcand,
	input wire logic [15:0] mplier,
	output logic done,
	output logic signed [49:0] product
);
	logic [15:0] m_q;
	logic signed [49:0] a_q;
	logic [4:0] n_q;
	logic busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			n_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				n_q <= '0;
				m_q <= mplier;
				a_q <= {{16{mcand[33]}}, mcand};
				product <= '0;
			end else if (busy_q) begin
				if (m_q[0]) product <= product + a_q;
				m_q <= m_q >> 1;
				a_q <= a_q <<< 1;
				n_q <= n_q + 1'b1;
				if (n_q == 5'd15) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire
